@@ rtl/lbar_pkg.sv @@
// Shared types, codes and pattern functions for the two-colour LED bar animator.
// Used by lbar_core and two_color_led_bar_animator_unit; depends on nothing else.
`default_nettype none

package lbar_pkg;

   localparam int unsigned LedCount       = 16;
   localparam int unsigned ActionWidth    = 3;
   localparam logic [15:0] LineDots       = 16'b0000_0001_0000_0001;
   localparam logic [15:0] PeriodReset    = 16'd1000;
   localparam logic signed [16:0] LineOffset = 17'sd4;
   localparam logic signed [16:0] LineMax    = 17'sd9;

   typedef enum logic [ActionWidth-1:0] {
      ACT_TICK   = 3'd0,
      ACT_LINE   = 3'd1,
      ACT_ROTATE = 3'd2,
      ACT_METER  = 3'd3,
      ACT_OFF    = 3'd4
   } action_type;

   typedef enum logic [1:0] {
      MODE_OFF    = 2'd0,
      MODE_STATIC = 2'd1,
      MODE_ROTATE = 2'd2
   } mode_type;

   typedef struct packed {
      logic [1:0]          mode;
      logic                phase;
      logic [LedCount-1:0] red;
      logic [LedCount-1:0] green;
      logic [15:0]         count;
   } lbar_state_type;

   typedef struct packed {
      logic                valid;
      logic                led_enable;
      logic                show_red;
      logic [LedCount-1:0] led_pattern;
   } lbar_rsp_type;

   function automatic logic [LedCount-1:0] rotate_right_one(input logic [LedCount-1:0] value);
      rotate_right_one = {value[0], value[LedCount-1:1]};
   endfunction

   function automatic logic [LedCount-1:0] line_pattern(input logic [3:0] amount);
      logic [2*LedCount-1:0] doubled;
      doubled      = {LineDots, LineDots} >> amount;
      line_pattern = doubled[LedCount-1:0];
   endfunction

   function automatic logic [LedCount-1:0] bar_pattern(input logic [3:0] nibble);
      bar_pattern = 16'hffff >> (4'd15 - nibble);
   endfunction

endpackage

`default_nettype wire

@@ rtl/lbar_core.sv @@
// Combinational request handling: next display state and the optional result.
// Depends on lbar_pkg for the state and result structs and pattern functions.
`default_nettype none

module lbar_core import lbar_pkg::*; (
   input  wire  lbar_state_type state,
   input  wire  logic [15:0]    period,
   input  wire  logic [2:0]     action,
   input  wire  logic signed [15:0] line_position,
   input  wire  logic           red_first,
   input  wire  logic [15:0]    red_load,
   input  wire  logic [15:0]    green_load,
   input  wire  logic [15:0]    meter_value,
   output lbar_state_type       next_state,
   output lbar_rsp_type         rsp
);

   logic signed [16:0] pos_sum;
   logic [3:0]         pos_clamped;
   logic [15:0]        dots;
   logic [15:0]        upper_bar;
   logic [15:0]        lower_bar;
   logic [15:0]        count_inc;

   always_comb begin
      pos_sum = 17'(signed'(line_position)) + LineOffset;
      if (pos_sum < 17'sd0) begin
         pos_clamped = 4'd0;
      end else if (pos_sum > LineMax) begin
         pos_clamped = LineMax[3:0];
      end else begin
         pos_clamped = pos_sum[3:0];
      end
      dots      = line_pattern(pos_clamped);
      upper_bar = bar_pattern(meter_value[15:12]);
      lower_bar = bar_pattern(meter_value[11:8]);
      count_inc = state.count + 16'd1;
   end

   always_comb begin
      next_state      = state;
      rsp.valid       = 1'b0;
      rsp.led_enable  = 1'b0;
      rsp.show_red    = 1'b0;
      rsp.led_pattern = '0;
      case (action)
         ACT_TICK: begin
            if (state.mode == MODE_STATIC || state.mode == MODE_ROTATE) begin
               next_state.phase = ~state.phase;
               rsp.valid        = 1'b1;
               rsp.led_enable   = 1'b1;
               rsp.show_red     = ~state.phase;
               rsp.led_pattern  = state.phase ? state.green : state.red;
               if (state.mode == MODE_ROTATE) begin
                  if (count_inc > period) begin
                     next_state.red   = rotate_right_one(state.red);
                     next_state.green = rotate_right_one(state.green);
                     next_state.count = '0;
                  end else begin
                     next_state.count = count_inc;
                  end
               end
            end
         end
         ACT_LINE: begin
            next_state.red   = red_first ? dots : ~dots;
            next_state.green = red_first ? ~dots : dots;
            next_state.mode  = MODE_STATIC;
         end
         ACT_ROTATE: begin
            next_state.red   = red_load;
            next_state.green = green_load;
            next_state.count = '0;
            next_state.mode  = MODE_ROTATE;
         end
         ACT_METER: begin
            next_state.red   = red_first ? upper_bar : lower_bar;
            next_state.green = red_first ? lower_bar : upper_bar;
            next_state.mode  = MODE_STATIC;
         end
         ACT_OFF: begin
            next_state.mode = MODE_OFF;
            rsp.valid       = 1'b1;
         end
         default: begin
         end
      endcase
   end

endmodule

`default_nettype wire

@@ rtl/two_color_led_bar_animator_unit.sv @@
// Top level of the two-colour LED bar animator: request register, display state,
// rotation period register and result register. Depends on lbar_pkg and lbar_core.
// A request is held in the request register; its result, if any, is registered into the result register.
// Throughput: one request per cycle; a stalled result holds the request register full.
// Reset (synchronous, active high) turns the display off, clears patterns, phase and
// count, and sets the rotation period to 1000.
`default_nettype none

module two_color_led_bar_animator_unit import lbar_pkg::*; (
   input  wire  logic               clock,
   input  wire  logic               reset,
   input  wire  logic               csr_write_enable,
   input  wire  logic [15:0]        csr_write_data,
   input  wire  logic               req_valid,
   output logic                     req_stall,
   input  wire  logic [2:0]         req_action,
   input  wire  logic signed [15:0] req_line_position,
   input  wire  logic               req_red_first,
   input  wire  logic [15:0]        req_red_load,
   input  wire  logic [15:0]        req_green_load,
   input  wire  logic [15:0]        req_meter_value,
   output logic                     rsp_valid,
   input  wire  logic               rsp_stall,
   output logic                     rsp_led_enable,
   output logic                     rsp_show_red,
   output logic [15:0]              rsp_led_pattern
);

   logic               in_valid_ff;
   logic [2:0]         in_action_ff;
   logic signed [15:0] in_position_ff;
   logic               in_red_first_ff;
   logic [15:0]        in_red_load_ff;
   logic [15:0]        in_green_load_ff;
   logic [15:0]        in_meter_ff;
   logic [15:0]        period_ff;
   lbar_state_type     state_ff;
   lbar_state_type     state_in;
   lbar_rsp_type       rsp_in;
   logic               rsp_valid_ff;
   logic               rsp_enable_ff;
   logic               rsp_red_ff;
   logic [15:0]        rsp_pattern_ff;
   logic               advance;

   assign advance   = in_valid_ff && !(rsp_valid_ff && rsp_stall);
   assign req_stall = in_valid_ff && !advance;

   lbar_core u_core (
      .state         (state_ff),
      .period        (period_ff),
      .action        (in_action_ff),
      .line_position (in_position_ff),
      .red_first     (in_red_first_ff),
      .red_load      (in_red_load_ff),
      .green_load    (in_green_load_ff),
      .meter_value   (in_meter_ff),
      .next_state    (state_in),
      .rsp           (rsp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= PeriodReset;
      end else if (csr_write_enable) begin
         period_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_action_ff     <= req_action;
         in_position_ff   <= req_line_position;
         in_red_first_ff  <= req_red_first;
         in_red_load_ff   <= req_red_load;
         in_green_load_ff <= req_green_load;
         in_meter_ff      <= req_meter_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '{mode: MODE_OFF, phase: 1'b0, red: '0, green: '0, count: '0};
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= rsp_in.valid;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && rsp_in.valid) begin
         rsp_enable_ff  <= rsp_in.led_enable;
         rsp_red_ff     <= rsp_in.show_red;
         rsp_pattern_ff <= rsp_in.led_pattern;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_led_enable  = rsp_enable_ff;
   assign rsp_show_red    = rsp_red_ff;
   assign rsp_led_pattern = rsp_pattern_ff;

endmodule

`default_nettype wire

@@ tb/tb.sv @@
// Self-checking testbench for two_color_led_bar_animator_unit, with its own model of the
// bar's patterns, colour phase and rotation count. It needs lbar_pkg and the unit's RTL.
`timescale 1ns / 1ps

module tb import lbar_pkg::*; ();

   localparam int unsigned CycleLimit   = 1000000;
   localparam int unsigned RandomPerRun = 475;
   localparam bit [2:0] ActSpareFirst   = 3'd5;
   localparam bit [2:0] ActSpareLast    = 3'd7;
   localparam bit [15:0] DotPair        = 16'h0101;

   typedef struct {
      bit [2:0]         action;
      bit signed [15:0] position;
      bit               red_first;
      bit [15:0]        red_load;
      bit [15:0]        green_load;
      bit [15:0]        meter_value;
   } led_request_type;

   class led_frame_checker;
      typedef struct {
         bit        enable;
         bit        show_red;
         bit [15:0] pattern;
      } led_frame_type;

      mode_type      mode;
      bit            phase;
      bit [15:0]     red;
      bit [15:0]     green;
      bit [15:0]     count;
      bit [15:0]     period;
      led_frame_type frames_due[$];
      int            mismatches;

      function new();
         mode       = MODE_OFF;
         phase      = 1'b0;
         red        = '0;
         green      = '0;
         count      = '0;
         period     = 16'd1000;
         mismatches = 0;
      endfunction

      function void set_period(bit [15:0] value);
         period = value;
      endfunction

      function bit [15:0] spin_right(bit [15:0] value, int unsigned places);
         bit [15:0] result;
         result = value;
         repeat (places) result = {result[0], result[15:1]};
         return result;
      endfunction

      function bit [15:0] bar_of(bit [3:0] nibble);
         bit [16:0] wide;
         wide = (17'd1 << (nibble + 5'd1)) - 17'd1;
         return wide[15:0];
      endfunction

      function void note_request(bit [2:0] action, bit signed [15:0] position,
                                 bit red_first, bit [15:0] red_load,
                                 bit [15:0] green_load, bit [15:0] meter_value);
         int            place;
         bit [15:0]     dots;
         led_frame_type frame;
         case (action)
            ACT_TICK: begin
               if (mode == MODE_STATIC || mode == MODE_ROTATE) begin
                  phase          = ~phase;
                  frame.enable   = 1'b1;
                  frame.show_red = phase;
                  frame.pattern  = phase ? red : green;
                  frames_due.push_back(frame);
                  if (mode == MODE_ROTATE) begin
                     count = count + 16'd1;
                     if (count > period) begin
                        red   = spin_right(red, 1);
                        green = spin_right(green, 1);
                        count = '0;
                     end
                  end
               end
            end
            ACT_LINE: begin
               place = int'(position) + 4;
               if (place < 0) place = 0;
               if (place > 9) place = 9;
               dots = spin_right(DotPair, place);
               if (red_first) begin
                  red   = dots;
                  green = ~dots;
               end else begin
                  green = dots;
                  red   = ~dots;
               end
               mode = MODE_STATIC;
            end
            ACT_ROTATE: begin
               red   = red_load;
               green = green_load;
               count = '0;
               mode  = MODE_ROTATE;
            end
            ACT_METER: begin
               if (red_first) begin
                  red   = bar_of(meter_value[15:12]);
                  green = bar_of(meter_value[11:8]);
               end else begin
                  green = bar_of(meter_value[15:12]);
                  red   = bar_of(meter_value[11:8]);
               end
               mode = MODE_STATIC;
            end
            ACT_OFF: begin
               mode           = MODE_OFF;
               frame.enable   = 1'b0;
               frame.show_red = 1'b0;
               frame.pattern  = '0;
               frames_due.push_back(frame);
            end
            default: begin
            end
         endcase
      endfunction

      function void check_frame(logic enable, logic show_red, logic [15:0] pattern);
         led_frame_type want;
         if (frames_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected frame: enable=%b show_red=%b pattern=%h",
                        enable, show_red, pattern);
            return;
         end
         want = frames_due.pop_front();
         if (enable !== want.enable || show_red !== want.show_red ||
             pattern !== want.pattern) begin
            mismatches++;
            if (mismatches <= 10)
               $display("frame mismatch: expected enable=%b show_red=%b pattern=%h, got %b %b %h",
                        want.enable, want.show_red, want.pattern, enable, show_red, pattern);
         end
      endfunction
   endclass

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               csr_write_enable = 1'b0;
   logic [15:0]        csr_write_data = '0;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [2:0]         req_action = ACT_TICK;
   logic signed [15:0] req_line_position = '0;
   logic               req_red_first = 1'b0;
   logic [15:0]        req_red_load = '0;
   logic [15:0]        req_green_load = '0;
   logic [15:0]        req_meter_value = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic               rsp_led_enable;
   logic               rsp_show_red;
   logic [15:0]        rsp_led_pattern;

   led_frame_checker board;
   int unsigned      send_idle_pct = 0;
   int unsigned      stall_pct = 0;
   int unsigned      cycle_count = 0;

   two_color_led_bar_animator_unit u_dut (
      .clock             (clock),
      .reset             (reset),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_action        (req_action),
      .req_line_position (req_line_position),
      .req_red_first     (req_red_first),
      .req_red_load      (req_red_load),
      .req_green_load    (req_green_load),
      .req_meter_value   (req_meter_value),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_led_enable    (rsp_led_enable),
      .rsp_show_red      (rsp_show_red),
      .rsp_led_pattern   (rsp_led_pattern)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall)
            board.check_frame(rsp_led_enable, rsp_show_red, rsp_led_pattern);
         if (req_valid && !req_stall)
            board.note_request(req_action, req_line_position, req_red_first,
                               req_red_load, req_green_load, req_meter_value);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("two_color_led_bar_animator_unit verification failed");
         $finish;
      end
   end

   function automatic led_request_type build_request(bit [2:0] action,
                                                     bit signed [15:0] position,
                                                     bit red_first, bit [15:0] red_load,
                                                     bit [15:0] green_load,
                                                     bit [15:0] meter_value);
      led_request_type r;
      r.action      = action;
      r.position    = position;
      r.red_first   = red_first;
      r.red_load    = red_load;
      r.green_load  = green_load;
      r.meter_value = meter_value;
      return r;
   endfunction

   function automatic led_request_type random_request();
      led_request_type r;
      int unsigned     pick;
      pick = $urandom_range(99);
      if (pick < 8)       r.action = ACT_LINE;
      else if (pick < 17) r.action = ACT_ROTATE;
      else if (pick < 26) r.action = ACT_METER;
      else if (pick < 32) r.action = ACT_OFF;
      else if (pick < 36) r.action = 3'($urandom_range(ActSpareLast, ActSpareFirst));
      else                r.action = ACT_TICK;
      if ($urandom_range(1))
         r.position = 16'($urandom_range(12) - 8);
      else
         r.position = 16'($urandom);
      r.red_first   = 1'($urandom);
      r.red_load    = 16'($urandom);
      r.green_load  = 16'($urandom);
      r.meter_value = 16'($urandom);
      return r;
   endfunction

   task automatic send_request(input led_request_type r);
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_action        <= r.action;
      req_line_position <= r.position;
      req_red_first     <= r.red_first;
      req_red_load      <= r.red_load;
      req_green_load    <= r.green_load;
      req_meter_value   <= r.meter_value;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (board.frames_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_period(input bit [15:0] value);
      settle();
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      board.set_period(value);
   endtask

   task automatic run_ticks(input bit [15:0] red_load, input bit [15:0] green_load,
                            input int unsigned ticks);
      send_request(build_request(ACT_ROTATE, '0, 1'b0, red_load, green_load, '0));
      repeat (ticks) send_request(build_request(ACT_TICK, '0, 1'b0, '0, '0, '0));
   endtask

   initial begin
      led_request_type directed[$];
      int unsigned     idle_plan[4]  = '{0, 61, 0, 13};
      int unsigned     stall_plan[4] = '{0, 0, 61, 13};
      bit [15:0]       period_plan[4];

      board = new();
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      directed.push_back(build_request(ACT_TICK,   '0,       1'b1, '0, '0, '0));
      directed.push_back(build_request(ACT_OFF,    '0,       1'b0, '0, '0, '0));
      directed.push_back(build_request(ACT_LINE,   16'sh8000, 1'b1, '0, '0, '0));
      directed.push_back(build_request(ACT_TICK,   '0,       1'b0, '0, '0, '0));
      directed.push_back(build_request(ACT_TICK,   '0,       1'b0, '0, '0, '0));
      directed.push_back(build_request(ACT_LINE,   16'sd32767, 1'b0, '0, '0, '0));
      directed.push_back(build_request(ACT_TICK,   '0,       1'b0, '0, '0, '0));
      directed.push_back(build_request(ACT_LINE,   -16'sd4,  1'b1, '0, '0, '0));
      directed.push_back(build_request(ACT_TICK,   '0,       1'b0, '0, '0, '0));
      directed.push_back(build_request(ACT_LINE,   16'sd5,   1'b0, '0, '0, '0));
      directed.push_back(build_request(ACT_TICK,   '0,       1'b0, '0, '0, '0));
      directed.push_back(build_request(ACT_LINE,   16'sd0,   1'b1, '0, '0, '0));
      directed.push_back(build_request(ACT_TICK,   '0,       1'b0, '0, '0, '0));
      directed.push_back(build_request(ACT_METER,  '0,       1'b1, '0, '0, 16'hffff));
      directed.push_back(build_request(ACT_TICK,   '0,       1'b0, '0, '0, '0));
      directed.push_back(build_request(ACT_TICK,   '0,       1'b0, '0, '0, '0));
      directed.push_back(build_request(ACT_METER,  '0,       1'b0, '0, '0, 16'h00ff));
      directed.push_back(build_request(ACT_TICK,   '0,       1'b0, '0, '0, '0));
      directed.push_back(build_request(ACT_ROTATE, '0, 1'b0, 16'hffff, 16'h0000, '0));
      directed.push_back(build_request(ACT_TICK,   '0,       1'b0, '0, '0, '0));
      directed.push_back(build_request(ActSpareFirst, -16'sd1, 1'b1,
                                       16'hffff, 16'hffff, 16'hffff));
      directed.push_back(build_request(ActSpareLast, -16'sd1, 1'b1,
                                       16'hffff, 16'hffff, 16'hffff));
      directed.push_back(build_request(ACT_TICK,   '0,       1'b0, '0, '0, '0));
      directed.push_back(build_request(ACT_OFF,    '0,       1'b1, '0, '0, '0));
      directed.push_back(build_request(ACT_TICK,   '0,       1'b0, '0, '0, '0));
      foreach (directed[i]) send_request(directed[i]);

      period_plan[0] = 16'd0;
      period_plan[1] = 16'hffff;
      period_plan[2] = 16'd1;
      period_plan[3] = 16'($urandom_range(9, 2));
      for (int run = 0; run < 4; run++) begin
         write_period(period_plan[run]);
         send_idle_pct = idle_plan[run];
         stall_pct     = stall_plan[run];
         repeat (RandomPerRun) send_request(random_request());
      end

      // A short period crossed a few times with fixed patterns.
      send_idle_pct = 0;
      stall_pct     = 0;
      write_period(16'd3);
      run_ticks(16'h8421, 16'h00f3, 13);

      settle();
      repeat (10) @(posedge clock);
      if (board.mismatches == 0 && board.frames_due.size() == 0)
         $display("two_color_led_bar_animator_unit verification clean");
      else
         $display("two_color_led_bar_animator_unit verification failed");
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/lbar_pkg.sv
rtl/lbar_core.sv
rtl/two_color_led_bar_animator_unit.sv
tb/tb.sv
